// ----- rtl/csr_pkg.sv -----
// Shared constants, codes and tables for the clear-sky radiation block.
// No dependencies; imported by csr_cordic, the top level and the checker.
`default_nettype none
package csr_pkg;

    // CORDIC depth
    localparam int CORDIC_STAGES_DEF = 18;
    localparam int ATAN_LEN          = 30;

    // Configuration register indexes
    localparam logic REG_DAY_OF_YEAR = 1'b0;
    localparam logic REG_HOUR_OF_DAY = 1'b1;

    // Field widths
    localparam int LAT_W   = 15;
    localparam int ELEV_W  = 15;
    localparam int RAD_W   = 18;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 24;
    localparam int CFG_DATA_W = 9;

    // Q2.30 constants; DEC_AMPL is a binary angle (full turn = 2^32)
    localparam logic signed [33:0] CORDIC_GAIN_INV = 34'sd652032874;
    localparam logic signed [26:0] DR_COEF  = 27'sd35433480;
    localparam logic signed [29:0] DEC_AMPL = 30'sd279769397;
    localparam logic [31:0]        Q30_ONE  = 32'h4000_0000;

    localparam logic [RAD_W-1:0] RAD_MAX = 18'd200000;

    // Arctangent table in binary angles (full turn = 2^32)
    function automatic logic [31:0] atan_bam(input int idx);
        logic [31:0] v;
        case (idx)
            0:  v = 32'd536870912;
            1:  v = 32'd316933406;
            2:  v = 32'd167458907;
            3:  v = 32'd85004756;
            4:  v = 32'd42667331;
            5:  v = 32'd21354465;
            6:  v = 32'd10679838;
            7:  v = 32'd5340245;
            8:  v = 32'd2670163;
            9:  v = 32'd1335087;
            10: v = 32'd667544;
            11: v = 32'd333772;
            12: v = 32'd166886;
            13: v = 32'd83443;
            14: v = 32'd41722;
            15: v = 32'd20861;
            16: v = 32'd10430;
            17: v = 32'd5215;
            18: v = 32'd2608;
            19: v = 32'd1304;
            20: v = 32'd652;
            21: v = 32'd326;
            22: v = 32'd163;
            23: v = 32'd81;
            24: v = 32'd41;
            25: v = 32'd20;
            26: v = 32'd10;
            27: v = 32'd5;
            28: v = 32'd3;
            default: v = 32'd1;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/csr_cordic.sv -----
// Pipelined rotation-mode CORDIC: binary angle in, Q2.30 sine and cosine out.
// Depends on csr_pkg (gain, arctangent table). Angle, stages and output are registered.
`default_nettype none
module csr_cordic #(
    parameter int STAGES = csr_pkg::CORDIC_STAGES_DEF
) (
    input  wire logic               aclk,
    input  wire logic               en,
    input  wire logic [31:0]        angle,
    output logic signed [31:0]      sin_q,
    output logic signed [31:0]      cos_q
);
    import csr_pkg::*;

    localparam int NST = (STAGES > ATAN_LEN) ? ATAN_LEN : STAGES;

    logic signed [33:0] x_reg [0:NST];
    logic signed [33:0] y_reg [0:NST];
    logic signed [33:0] z_reg [0:NST];
    logic               flip_reg [0:NST];

    logic        flip_in;
    logic [31:0] ang_f;

    // Fold angles beyond +-90 deg by half a turn; negate results at the end
    always_comb begin
        flip_in = (angle[31:30] == 2'b01) || (angle[31:30] == 2'b10);
        ang_f   = flip_in ? (angle + 32'h8000_0000) : angle;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0]    <= CORDIC_GAIN_INV;
            y_reg[0]    <= '0;
            z_reg[0]    <= 34'($signed(ang_f));
            flip_reg[0] <= flip_in;
        end
    end

    for (genvar i = 0; i < NST; i++) begin : g_iter
        always_ff @(posedge aclk) begin
            if (en) begin
                flip_reg[i+1] <= flip_reg[i];
                if (z_reg[i] >= 0) begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - $signed({2'b00, atan_bam(i)});
                end else begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + $signed({2'b00, atan_bam(i)});
                end
            end
        end
    end

    logic signed [33:0] x_fin;
    logic signed [33:0] y_fin;
    always_comb begin
        x_fin = flip_reg[NST] ? -x_reg[NST] : x_reg[NST];
        y_fin = flip_reg[NST] ? -y_reg[NST] : y_reg[NST];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cos_q <= x_fin[31:0];
            sin_q <= y_fin[31:0];
        end
    end

endmodule
`default_nettype wire

// ----- rtl/clear_sky_solar_radiation.sv -----
// Top level of the clear-sky radiation block: config terms and the item pipeline.
// Depends on csr_pkg and csr_cordic; csr_checker binds to it.
//
//  channel  dir  handshake         payload
//  s_       in   s_tvalid/tready   s_tdata: latitude[14:0], elevation[29:15]; s_tlast
//  m_       out  m_tvalid/tready   m_tdata: radiation[17:0]; m_tlast
//  cfg_     in   cfg_wr_en         cfg_wr_index, cfg_wr_data (no read-back)
//
// One item enters per cycle while s_tready is high; the item path is the capped stages + 12
// pipeline registers plus the output register, set by the latitude CORDIC chain.
// Reset (aresetn low, synchronous) clears both registers, all valid bits and output valid.
// After reset and after every configuration write, s_tready stays low until the settle
// counter runs out, while the day, hour and declination terms settle.
// A stall on m_tready holds the output item; the pipeline keeps moving while its last slot is empty.
`default_nettype none
module clear_sky_solar_radiation #(
    parameter int CORDIC_STAGES = csr_pkg::CORDIC_STAGES_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // s_tdata: latitude [14:0], elevation [29:15], zero fill [31:30]
    input  wire logic [csr_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic                          s_tvalid,
    input  wire logic                          s_tlast,
    output logic                               s_tready,
    // m_tdata: radiation [17:0], zero fill [23:18]
    output logic [csr_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                               m_tvalid,
    output logic                               m_tlast,
    input  wire logic                          m_tready,
    input  wire logic                          cfg_wr_en,
    input  wire logic                          cfg_wr_index,
    input  wire logic [csr_pkg::CFG_DATA_W-1:0] cfg_wr_data
);
    import csr_pkg::*;

    localparam int NST     = (CORDIC_STAGES > ATAN_LEN) ? ATAN_LEN : CORDIC_STAGES;
    localparam int DEPTH   = NST + 12;
    localparam int ELEV_D  = NST + 9;
    localparam int SETTLE  = 2 * NST + 12;
    localparam int SET_W   = $clog2(SETTLE + 1);

    // ------------------------------------------------------------------
    // Configuration registers and settle counter
    // ------------------------------------------------------------------
    logic [8:0]       day_reg;
    logic [4:0]       hour_reg;
    logic [SET_W-1:0] settle_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            day_reg    <= '0;
            hour_reg   <= '0;
            settle_reg <= SET_W'(SETTLE);
        end else begin
            if (cfg_wr_en) begin
                settle_reg <= SET_W'(SETTLE);
                unique case (cfg_wr_index)
                    REG_DAY_OF_YEAR: day_reg  <= cfg_wr_data[8:0];
                    REG_HOUR_OF_DAY: hour_reg <= cfg_wr_data[4:0];
                endcase
            end else if (settle_reg != '0) begin
                settle_reg <= settle_reg - SET_W'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Config terms, free running. Day angle = k*2^32/365 rounded:
    // k*11766899 + floor((k*49161 + 182)/365), quotient by reciprocal.
    // ------------------------------------------------------------------
    logic [8:0]  dm;
    logic [9:0]  k_dec;
    logic [31:0] c1_base_d_reg, c1_base_k_reg, c1_hr_ang_reg;
    logic [24:0] c1_n_d_reg, c1_n_k_reg;
    logic [31:0] c2_base_d_reg, c2_base_k_reg;
    logic [16:0] c2_q_d_reg, c2_q_k_reg;
    logic [31:0] c3_ang_d_reg, c3_ang_k_reg;
    logic [31:0] hb;
    logic [6:0]  hv;
    logic [12:0] hq_prod;
    logic [50:0] q_d_prod, q_k_prod;

    always_comb begin
        dm      = (day_reg >= 9'd365) ? (day_reg - 9'd365) : day_reg;
        k_dec   = 10'd537 - {1'b0, dm};
        // hour angle = h*178956970 + floor((4h+3)/6), quotient via *43>>8
        hb      = {27'b0, hour_reg} * 32'd178956970;
        hv      = {hour_reg, 2'b11};
        hq_prod = {6'b0, hv} * 13'd43;
        q_d_prod = {26'b0, c1_n_d_reg} * 51'd47068135;
        q_k_prod = {26'b0, c1_n_k_reg} * 51'd47068135;
    end

    always_ff @(posedge aclk) begin
        c1_base_d_reg <= {23'b0, day_reg} * 32'd11766899;
        c1_base_k_reg <= {22'b0, k_dec} * 32'd11766899;
        c1_n_d_reg    <= {16'b0, day_reg} * 25'd49161 + 25'd182;
        c1_n_k_reg    <= {15'b0, k_dec} * 25'd49161 + 25'd182;
        c1_hr_ang_reg <= hb + {27'b0, hq_prod[12:8]};
        c2_base_d_reg <= c1_base_d_reg;
        c2_base_k_reg <= c1_base_k_reg;
        c2_q_d_reg    <= q_d_prod[50:34];
        c2_q_k_reg    <= q_k_prod[50:34];
        c3_ang_d_reg  <= c2_base_d_reg + {15'b0, c2_q_d_reg};
        c3_ang_k_reg  <= c2_base_k_reg + {15'b0, c2_q_k_reg};
    end

    logic signed [31:0] cos_day, cos_k, cos_hr, sin_dec, cos_dec;

    csr_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_day (
        .aclk(aclk), .en(1'b1), .angle(c3_ang_d_reg), .sin_q(), .cos_q(cos_day)
    );
    csr_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_season (
        .aclk(aclk), .en(1'b1), .angle(c3_ang_k_reg), .sin_q(), .cos_q(cos_k)
    );
    csr_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_hour (
        .aclk(aclk), .en(1'b1), .angle(c1_hr_ang_reg), .sin_q(), .cos_q(cos_hr)
    );

    // Distance factor and declination angle
    logic signed [63:0] dr_prod, dec_prod;
    logic signed [31:0] dr_reg;
    logic [31:0]        dec_ang_reg;

    always_comb begin
        dr_prod  = cos_day * DR_COEF;
        dec_prod = cos_k * DEC_AMPL;
    end

    always_ff @(posedge aclk) begin
        dr_reg      <= $signed(Q30_ONE + dr_prod[61:30]);
        dec_ang_reg <= dec_prod[61:30];
    end

    csr_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_dec (
        .aclk(aclk), .en(1'b1), .angle(dec_ang_reg), .sin_q(sin_dec), .cos_q(cos_dec)
    );

    // ------------------------------------------------------------------
    // Item pipeline: valid, last and elevation travel alongside
    // ------------------------------------------------------------------
    logic                     adv, out_free, accept;
    logic                     vld_reg  [1:DEPTH];
    logic                     last_reg [1:DEPTH];
    logic signed [ELEV_W-1:0] elev_reg [1:ELEV_D];

    always_comb begin
        out_free = !m_tvalid || m_tready;
        adv      = out_free || !vld_reg[DEPTH];
        s_tready = adv && (settle_reg == '0);
        accept   = s_tvalid && s_tready;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 1; i <= DEPTH; i++) vld_reg[i] <= 1'b0;
        end else if (adv) begin
            vld_reg[1] <= accept;
            for (int i = 2; i <= DEPTH; i++) vld_reg[i] <= vld_reg[i-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            last_reg[1] <= s_tlast;
            elev_reg[1] <= $signed(s_tdata[LAT_W +: ELEV_W]);
            for (int i = 2; i <= DEPTH; i++) last_reg[i] <= last_reg[i-1];
            for (int i = 2; i <= ELEV_D; i++) elev_reg[i] <= elev_reg[i-1];
        end
    end

    // Latitude angle = round(|lat|*2^32/36000):
    // |lat|*119304 + floor((|lat|*23296 + 18000)/36000)
    logic signed [LAT_W-1:0] lat_in;
    logic [LAT_W-1:0]        lat_abs;
    logic                    p1_neg_reg, p2_neg_reg;
    logic [31:0]             p1_base_reg, p2_base_reg, p3_ang_reg;
    logic [28:0]             p1_n_reg;
    logic [13:0]             p2_q_reg;
    logic [58:0]             lat_q_prod;
    logic [31:0]             lat_mag;

    always_comb begin
        lat_in     = $signed(s_tdata[LAT_W-1:0]);
        lat_abs    = lat_in[LAT_W-1] ? LAT_W'(-lat_in) : LAT_W'(lat_in);
        lat_q_prod = {30'b0, p1_n_reg} * 59'd977343670;
        lat_mag    = p2_base_reg + {18'b0, p2_q_reg};
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p1_neg_reg  <= lat_in[LAT_W-1];
            p1_base_reg <= {17'b0, lat_abs} * 32'd119304;
            p1_n_reg    <= {14'b0, lat_abs} * 29'd23296 + 29'd18000;
            p2_neg_reg  <= p1_neg_reg;
            p2_base_reg <= p1_base_reg;
            p2_q_reg    <= lat_q_prod[58:45];
            p3_ang_reg  <= p2_neg_reg ? (32'd0 - lat_mag) : lat_mag;
        end
    end

    logic signed [31:0] sin_lat, cos_lat;

    csr_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_lat (
        .aclk(aclk), .en(adv), .angle(p3_ang_reg), .sin_q(sin_lat), .cos_q(cos_lat)
    );

    // f = sin(lat)sin(dec) + cos(lat)cos(dec)cos(hour); keep -f where positive
    logic signed [63:0] m1_prod, m2_prod, m3_prod;
    logic signed [31:0] pa_m1_reg, pa_m2_reg, pb_m1_reg, pb_m3_reg;
    logic signed [32:0] f_sum, f_neg;
    logic signed [32:0] pc_neg_reg;
    logic signed [64:0] p_prod;
    logic [31:0]        pd_p_reg;
    logic signed [16:0] fac_s;
    logic [47:0]        pe_e_reg;
    logic [55:0]        num;
    logic [24:0]        pf_t_reg;
    logic [50:0]        r_prod;
    logic [20:0]        pg_r_reg;

    always_comb begin
        m1_prod = sin_lat * sin_dec;
        m2_prod = cos_lat * cos_dec;
        m3_prod = pa_m2_reg * cos_hr;
        f_sum   = 33'(pb_m1_reg) + 33'(pb_m3_reg);
        f_neg   = -f_sum;
        p_prod  = dr_reg * pc_neg_reg;
        fac_s   = 17'sd37500 + 17'(elev_reg[ELEV_D]);
        // e*68 + half of 25*2^30, then drop 30 bits
        num     = {2'b0, pe_e_reg, 6'b0} + {6'b0, pe_e_reg, 2'b0} + 56'd13421772800;
        r_prod  = {26'b0, pf_t_reg} * 51'd42949673;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            pa_m1_reg  <= m1_prod[61:30];
            pa_m2_reg  <= m2_prod[61:30];
            pb_m1_reg  <= pa_m1_reg;
            pb_m3_reg  <= m3_prod[61:30];
            pc_neg_reg <= (f_neg > 0) ? f_neg : '0;
            pd_p_reg   <= p_prod[61:30];
            pe_e_reg   <= {16'b0, pd_p_reg} * {32'b0, fac_s[15:0]};
            pf_t_reg   <= num[54:30];
            pg_r_reg   <= r_prod[50:30];
        end
    end

    // ------------------------------------------------------------------
    // Output register: saturate and hold until taken
    // ------------------------------------------------------------------
    logic [RAD_W-1:0] rad_sat;
    always_comb begin
        rad_sat = (pg_r_reg > {3'b0, RAD_MAX}) ? RAD_MAX : pg_r_reg[RAD_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid <= 1'b0;
        end else if (out_free) begin
            m_tvalid <= vld_reg[DEPTH];
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            m_tdata <= {{(M_TDATA_W-RAD_W){1'b0}}, rad_sat};
            m_tlast <= last_reg[DEPTH];
        end
    end

endmodule
`default_nettype wire

// ----- rtl/csr_checker.sv -----
// Port-level checks for the clear-sky radiation block, bound to its top level.
// Depends on csr_pkg for widths and the saturation limit.
`default_nettype none
module csr_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           s_tready,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [csr_pkg::M_TDATA_W-1:0]  m_tdata,
    input wire logic                           cfg_wr_en
);
    import csr_pkg::*;

    // Hold a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // Saturated and zero filled
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[RAD_W-1:0] <= RAD_MAX) && (m_tdata[M_TDATA_W-1:RAD_W] == '0))
        else $error("radiation out of range");

    // Input not ready after a config write
    a_settle: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr_en |=> !s_tready)
        else $error("input ready right after config write");

    // Reset drops output valid
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

bind clear_sky_solar_radiation csr_checker u_csr_checker (.*);
`default_nettype wire
